@@ src/fwt_pkg.sv @@
// Shared types and constants for the Fenwick tree range add / sum block.
// Used by fwt_ctrl, fwt_dp and fenwick_tree_range_add_sum; no dependencies.
package fwt_pkg;

  localparam int IDX_W  = 11;          // width of index and size fields
  localparam int WIDX_W = IDX_W + 1;   // walk index, room for i + lowbit(i)
  localparam int DATA_W = 64;

  localparam logic [IDX_W-1:0] SIZE_RESET = IDX_W'(1024);

  localparam logic [1:0] KIND_POINT_ADD = 2'd0;
  localparam logic [1:0] KIND_RANGE_ADD = 2'd1;
  localparam logic [1:0] KIND_PREFIX    = 2'd2;
  localparam logic [1:0] KIND_RANGE_SUM = 2'd3;

  typedef struct packed {
    logic              clear;
    logic              start;
    logic              add_mode;
    logic              neg;
    logic              acc_clr;
    logic [WIDX_W-1:0] pos;
    logic [IDX_W-1:0]  n;
    logic [DATA_W-1:0] value;
  } fwt_cmd_t;

  typedef struct packed {
    logic              clear_done;
    logic              walk_done;
    logic [DATA_W-1:0] acc;
  } fwt_sts_t;

endpackage

@@ src/fenwick_tree_range_add_sum.sv @@
// Top level of the Fenwick tree range add / range sum block.
// Depends on fwt_pkg, fwt_ctrl, fwt_dp (which holds fwt_ram).
//
//   channel | ports                                          | handshake
//   in      | in_kind in_first_index in_last_index in_add_value | in_valid / in_ready
//   out     | out_sum_result out_error_flag                  | out_valid / out_ready
//   cfg     | cfg_wdata (size_in_use)                        | cfg_we, no wait
//
// One word at a time. A tree walk of k steps makes one RAM read per cycle, with the
// read-modify-write overlapped; an item runs one walk and, where it needs one, a second,
// k <= log2(n) + 1, and a rejected word goes straight to the done state.
// After reset the RAM is swept to zero with in_ready low.
// A result waiting on out_ready holds the controller in its done state.
module fenwick_tree_range_add_sum #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                              clk,
  input  logic                              rst_n,
  input  logic                              cfg_we,
  input  logic [fwt_pkg::IDX_W-1:0]         cfg_wdata,
  input  logic                              in_valid,
  output logic                              in_ready,
  input  logic [1:0]                        in_kind,
  input  logic [fwt_pkg::IDX_W-1:0]         in_first_index,
  input  logic [fwt_pkg::IDX_W-1:0]         in_last_index,
  input  logic signed [fwt_pkg::DATA_W-1:0] in_add_value,
  output logic                              out_valid,
  input  logic                              out_ready,
  output logic signed [fwt_pkg::DATA_W-1:0] out_sum_result,
  output logic                              out_error_flag
);

  fwt_pkg::fwt_cmd_t cmd;
  fwt_pkg::fwt_sts_t sts;

  fwt_ctrl #(.MAX_ENTRIES(MAX_ENTRIES)) u_ctrl (
    .clk            (clk),
    .rst_n          (rst_n),
    .cfg_we         (cfg_we),
    .cfg_wdata      (cfg_wdata),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_kind        (in_kind),
    .in_first_index (in_first_index),
    .in_last_index  (in_last_index),
    .in_add_value   (in_add_value),
    .out_valid      (out_valid),
    .out_ready      (out_ready),
    .out_sum_result (out_sum_result),
    .out_error_flag (out_error_flag),
    .cmd            (cmd),
    .sts            (sts)
  );

  fwt_dp #(.MAX_ENTRIES(MAX_ENTRIES)) u_dp (
    .clk   (clk),
    .rst_n (rst_n),
    .cmd   (cmd),
    .sts   (sts)
  );

endmodule

@@ src/fwt_ram.sv @@
// Generic single-write, single-read RAM with registered read data.
// No dependencies.
module fwt_ram #(
  parameter int WIDTH = 64,
  parameter int DEPTH = 1024
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(DEPTH)-1:0] waddr,
  input  logic [WIDTH-1:0]         wdata,
  input  logic [$clog2(DEPTH)-1:0] raddr,
  output logic [WIDTH-1:0]         rdata
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata <= mem[raddr];
  end

endmodule

@@ src/fwt_dp.sv @@
// Datapath: tree store, walk index unit, accumulator and clearing sweep.
// Depends on fwt_pkg and fwt_ram; driven by fwt_ctrl through fwt_cmd_t.
module fwt_dp #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic             clk,
  input  logic             rst_n,
  input  fwt_pkg::fwt_cmd_t cmd,
  output fwt_pkg::fwt_sts_t sts
);

  localparam int AW = $clog2(MAX_ENTRIES);
  localparam int IW = fwt_pkg::WIDX_W;
  localparam int NW = fwt_pkg::IDX_W;
  localparam int DW = fwt_pkg::DATA_W;

  logic          active_r, active_nxt;
  logic          pend_r;
  logic          add_r;
  logic          neg_r;
  logic [NW-1:0] n_r;
  logic [IW-1:0] idx_r, idx_nxt;
  logic [DW-1:0] val_r;
  logic [DW-1:0] acc_r;
  logic [AW-1:0] paddr_r;
  logic [AW-1:0] clr_cnt_r;

  logic          in_range;
  logic          issue;
  logic          walk_done;
  logic [IW-1:0] lowbit;
  logic [IW-1:0] im1;
  logic [AW-1:0] raddr;
  logic          we;
  logic [AW-1:0] waddr;
  logic [DW-1:0] wdata;
  logic [DW-1:0] rdata;
  logic [DW-1:0] acc_opd;

  fwt_ram #(.WIDTH(DW), .DEPTH(MAX_ENTRIES)) u_ram (
    .clk   (clk),
    .we    (we),
    .waddr (waddr),
    .wdata (wdata),
    .raddr (raddr),
    .rdata (rdata)
  );

  always_comb begin
    in_range  = add_r ? ((idx_r != '0) && (idx_r <= {1'b0, n_r})) : (idx_r != '0);
    issue     = active_r && in_range;
    walk_done = active_r && !in_range;
    lowbit    = idx_r & (~idx_r + IW'(1));
    idx_nxt   = add_r ? (idx_r + lowbit) : (idx_r - lowbit);
    im1       = idx_r - IW'(1);
    raddr     = AW'(im1);
    acc_opd   = neg_r ? ~rdata : rdata;
    if (cmd.start) begin
      active_nxt = 1'b1;
    end else if (walk_done) begin
      active_nxt = 1'b0;
    end else begin
      active_nxt = active_r;
    end
    if (cmd.clear) begin
      we    = 1'b1;
      waddr = clr_cnt_r;
      wdata = '0;
    end else begin
      we    = pend_r && add_r;
      waddr = paddr_r;
      wdata = rdata + val_r;
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      active_r  <= 1'b0;
      pend_r    <= 1'b0;
      clr_cnt_r <= '0;
    end else begin
      active_r <= active_nxt;
      pend_r   <= issue;
      if (cmd.clear) begin
        clr_cnt_r <= clr_cnt_r + AW'(1);
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.start) begin
      idx_r <= cmd.pos;
      add_r <= cmd.add_mode;
      neg_r <= cmd.neg;
      n_r   <= cmd.n;
      val_r <= cmd.neg ? (~cmd.value + DW'(1)) : cmd.value;
    end else if (issue) begin
      idx_r <= idx_nxt;
    end
    if (issue) begin
      paddr_r <= raddr;
    end
    if (cmd.acc_clr) begin
      acc_r <= '0;
    end else if (pend_r && !add_r) begin
      acc_r <= acc_r + acc_opd + DW'(neg_r);
    end
  end

  assign sts.clear_done = cmd.clear && (clr_cnt_r == AW'(MAX_ENTRIES - 1));
  assign sts.walk_done  = walk_done;
  assign sts.acc        = acc_r;

endmodule

@@ src/fwt_ctrl.sv @@
// Controller: size register, index checks, walk sequencing and result word.
// Depends on fwt_pkg; commands fwt_dp through fwt_cmd_t / fwt_sts_t.
module fwt_ctrl #(
  parameter int MAX_ENTRIES = 1024
) (
  input  logic                           clk,
  input  logic                           rst_n,
  input  logic                           cfg_we,
  input  logic [fwt_pkg::IDX_W-1:0]      cfg_wdata,
  input  logic                           in_valid,
  output logic                           in_ready,
  input  logic [1:0]                     in_kind,
  input  logic [fwt_pkg::IDX_W-1:0]      in_first_index,
  input  logic [fwt_pkg::IDX_W-1:0]      in_last_index,
  input  logic signed [fwt_pkg::DATA_W-1:0] in_add_value,
  output logic                           out_valid,
  input  logic                           out_ready,
  output logic signed [fwt_pkg::DATA_W-1:0] out_sum_result,
  output logic                           out_error_flag,
  output fwt_pkg::fwt_cmd_t              cmd,
  input  fwt_pkg::fwt_sts_t              sts
);

  localparam int NW = fwt_pkg::IDX_W;
  localparam int IW = fwt_pkg::WIDX_W;
  localparam int DW = fwt_pkg::DATA_W;

  typedef enum logic [6:0] {
    S_CLEAR = 7'b0000001,
    S_IDLE  = 7'b0000010,
    S_W1S   = 7'b0000100,
    S_W1    = 7'b0001000,
    S_W2S   = 7'b0010000,
    S_W2    = 7'b0100000,
    S_DONE  = 7'b1000000
  } state_t;

  state_t        state_r, state_nxt;
  logic [NW-1:0] size_r;
  logic [1:0]    kind_r;
  logic [NW-1:0] first_r;
  logic [NW-1:0] last_r;
  logic [DW-1:0] val_r;
  logic [NW-1:0] n_r;
  logic          err_r;
  logic          out_valid_r;
  logic [DW-1:0] sum_r;
  logic          oerr_r;

  logic          accept;
  logic          out_load;
  logic [NW-1:0] n_eff;
  logic          first_ok;
  logic          range_ok;
  logic          err_in;
  logic          need2;

  always_comb begin
    if (size_r == '0) begin
      n_eff = NW'(1);
    end else if (32'(size_r) > 32'(MAX_ENTRIES)) begin
      n_eff = NW'(MAX_ENTRIES);
    end else begin
      n_eff = size_r;
    end
    first_ok = (in_first_index != '0) && (in_first_index <= n_eff);
    range_ok = first_ok && (in_last_index != '0) && (in_last_index <= n_eff) &&
               (in_first_index <= in_last_index);
    case (in_kind)
      fwt_pkg::KIND_POINT_ADD: err_in = !first_ok;
      fwt_pkg::KIND_PREFIX:    err_in = !first_ok;
      default:                 err_in = !range_ok;
    endcase
    need2 = ((kind_r == fwt_pkg::KIND_RANGE_ADD) && (last_r < n_r)) ||
            ((kind_r == fwt_pkg::KIND_RANGE_SUM) && (first_r > NW'(1)));
  end

  assign in_ready = (state_r == S_IDLE);
  assign accept   = in_valid && in_ready;
  assign out_load = (state_r == S_DONE) && (!out_valid_r || out_ready);

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (sts.clear_done) state_nxt = S_IDLE;
      S_IDLE:  if (accept) state_nxt = err_in ? S_DONE : S_W1S;
      S_W1S:   state_nxt = S_W1;
      S_W1:    if (sts.walk_done) state_nxt = need2 ? S_W2S : S_DONE;
      S_W2S:   state_nxt = S_W2;
      S_W2:    if (sts.walk_done) state_nxt = S_DONE;
      S_DONE:  if (out_load) state_nxt = S_IDLE;
      default: state_nxt = S_CLEAR;
    endcase
  end

  always_comb begin
    cmd          = '0;
    cmd.clear    = (state_r == S_CLEAR);
    cmd.start    = (state_r == S_W1S) || (state_r == S_W2S);
    cmd.acc_clr  = (state_r == S_W1S);
    cmd.neg      = (state_r == S_W2S);
    cmd.add_mode = (kind_r == fwt_pkg::KIND_POINT_ADD) ||
                   (kind_r == fwt_pkg::KIND_RANGE_ADD);
    cmd.n        = n_r;
    cmd.value    = val_r;
    if (state_r == S_W1S) begin
      cmd.pos = (kind_r == fwt_pkg::KIND_RANGE_SUM) ? IW'(last_r) : IW'(first_r);
    end else begin
      cmd.pos = (kind_r == fwt_pkg::KIND_RANGE_ADD) ? (IW'(last_r) + IW'(1))
                                                    : (IW'(first_r) - IW'(1));
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r     <= S_CLEAR;
      size_r      <= fwt_pkg::SIZE_RESET;
      out_valid_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (cfg_we) begin
        size_r <= cfg_wdata;
      end
      if (out_load) begin
        out_valid_r <= 1'b1;
      end else if (out_ready) begin
        out_valid_r <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      kind_r  <= in_kind;
      first_r <= in_first_index;
      last_r  <= in_last_index;
      val_r   <= in_add_value;
      n_r     <= n_eff;
      err_r   <= err_in;
    end
    if (out_load) begin
      sum_r  <= (err_r || cmd.add_mode) ? '0 : sts.acc;
      oerr_r <= err_r;
    end
  end

  assign out_valid      = out_valid_r;
  assign out_sum_result = sum_r;
  assign out_error_flag = oerr_r;

endmodule
